// ===== rtl/core/xcrc_pkg.sv =====
// shared types, character codes and the crc byte update for the xmodem-crc block receiver
// no dependencies; used by xcrc_step and xmodem_crc_block_receiver
package xcrc_pkg;

	localparam int unsigned SHORT_BLOCK = 128;
	localparam int unsigned LONG_BLOCK  = 1024;
	localparam int unsigned CNT_W       = 10;

	localparam logic [7:0] CH_SOH = 8'd1;
	localparam logic [7:0] CH_STX = 8'd2;
	localparam logic [7:0] CH_EOT = 8'd4;
	localparam logic [7:0] CH_ACK = 8'd6;
	localparam logic [7:0] CH_NAK = 8'd21;
	localparam logic [7:0] CH_CAN = 8'd24;
	localparam logic [7:0] CH_C   = 8'd67;

	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [23:0] TIMEOUT_RESET = 24'd60000;

	typedef enum logic [1:0] {
		MODE_BYTE,
		MODE_TICK,
		MODE_CANCEL,
		MODE_START
	} mode_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_WAIT,
		PH_NUM,
		PH_CPL,
		PH_DATA,
		PH_CRCH,
		PH_CRCL,
		PH_DONE,
		PH_ABORT
	} phase_t;

	typedef enum logic [1:0] {
		LINK_IDLE,
		LINK_RECEIVING,
		LINK_FINISHED,
		LINK_ABORTED
	} link_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic             reply_valid;
		logic [7:0]       reply_byte;
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [CNT_W-1:0] data_index;
		logic             block_commit;
		logic             block_discard;
		link_t            link_status;
	} result_t;

	// crc-16/xmodem, one byte msb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/xcrc_step.sv =====
// protocol state and per-request decision logic of the xmodem-crc block receiver
// depends on xcrc_pkg; instantiated by xmodem_crc_block_receiver
module xcrc_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  xcrc_pkg::item_t  item,
	input  logic [23:0]      timeout_ticks,
	output xcrc_pkg::result_t res
);

	xcrc_pkg::phase_t phase_q, phase_d;
	logic                       long_q, long_d;
	logic [7:0]                 number_q, number_d;
	logic [xcrc_pkg::CNT_W-1:0] count_q, count_d;
	logic [15:0]                crc_q, crc_d;
	logic [7:0]                 crc_hi_q, crc_hi_d;
	logic [7:0]                 expected_q, expected_d;
	logic [23:0]                idle_q, idle_d;

	logic                     receiving, in_block;
	logic [23:0]              tick_inc, timeout_lim;
	logic                     timeout_hit;
	logic [7:0]               cpl_sum, expected_prev;
	logic                     cpl_ok, crc_ok, num_new, num_dup;
	logic [xcrc_pkg::CNT_W:0] cnt_inc, block_len;
	logic                     last_byte;
	logic [15:0]              crc_next;
	logic [7:0]               b;

	assign b           = item.byte_value;
	assign receiving   = phase_q inside {[xcrc_pkg::PH_WAIT:xcrc_pkg::PH_CRCL]};
	assign in_block    = phase_q inside {[xcrc_pkg::PH_NUM:xcrc_pkg::PH_CRCL]};
	assign tick_inc    = idle_q + 24'd1;
	assign timeout_lim = (timeout_ticks == 24'd0) ? 24'd1 : timeout_ticks;
	assign timeout_hit = tick_inc >= timeout_lim;
	assign cpl_sum     = number_q + b;
	assign cpl_ok      = cpl_sum == 8'hFF;
	assign crc_ok      = {crc_hi_q, b} == crc_q;
	assign expected_prev = expected_q - 8'd1;
	assign num_new     = number_q == expected_q;
	assign num_dup     = number_q == expected_prev;
	assign cnt_inc     = {1'b0, count_q} + {{xcrc_pkg::CNT_W{1'b0}}, 1'b1};
	assign block_len   = long_q ? (xcrc_pkg::CNT_W+1)'(xcrc_pkg::LONG_BLOCK)
	                            : (xcrc_pkg::CNT_W+1)'(xcrc_pkg::SHORT_BLOCK);
	assign last_byte   = cnt_inc >= block_len;
	assign crc_next    = xcrc_pkg::crc_feed(crc_q, b);

	// next state
	always_comb begin
		phase_d    = phase_q;
		long_d     = long_q;
		number_d   = number_q;
		count_d    = count_q;
		crc_d      = crc_q;
		crc_hi_d   = crc_hi_q;
		expected_d = expected_q;
		idle_d     = idle_q;
		case (item.mode)
			xcrc_pkg::MODE_START: begin
				phase_d    = xcrc_pkg::PH_WAIT;
				expected_d = 8'd1;
				idle_d     = '0;
				count_d    = '0;
				crc_d      = '0;
			end
			xcrc_pkg::MODE_CANCEL: begin
				if (receiving) phase_d = xcrc_pkg::PH_ABORT;
			end
			xcrc_pkg::MODE_TICK: begin
				if (receiving) begin
					idle_d = tick_inc;
					if (timeout_hit) begin
						idle_d  = '0;
						phase_d = xcrc_pkg::PH_WAIT;
					end
				end
			end
			xcrc_pkg::MODE_BYTE: begin
				if (receiving) begin
					idle_d = '0;
					case (phase_q)
						xcrc_pkg::PH_WAIT: begin
							if (b == xcrc_pkg::CH_CAN) begin
								phase_d = xcrc_pkg::PH_ABORT;
							end else if (b == xcrc_pkg::CH_EOT) begin
								phase_d = xcrc_pkg::PH_DONE;
							end else if (b inside {xcrc_pkg::CH_SOH, xcrc_pkg::CH_STX}) begin
								long_d  = b == xcrc_pkg::CH_STX;
								phase_d = xcrc_pkg::PH_NUM;
							end
						end
						xcrc_pkg::PH_NUM: begin
							number_d = b;
							phase_d  = xcrc_pkg::PH_CPL;
						end
						xcrc_pkg::PH_CPL: begin
							if (cpl_ok) begin
								count_d = '0;
								crc_d   = '0;
								phase_d = xcrc_pkg::PH_DATA;
							end else begin
								phase_d = xcrc_pkg::PH_WAIT;
							end
						end
						xcrc_pkg::PH_DATA: begin
							crc_d   = crc_next;
							count_d = cnt_inc[xcrc_pkg::CNT_W-1:0];
							if (last_byte) begin
								count_d = '0;
								phase_d = xcrc_pkg::PH_CRCH;
							end
						end
						xcrc_pkg::PH_CRCH: begin
							crc_hi_d = b;
							phase_d  = xcrc_pkg::PH_CRCL;
						end
						xcrc_pkg::PH_CRCL: begin
							if (crc_ok && num_new) expected_d = expected_q + 8'd1;
							phase_d = xcrc_pkg::PH_WAIT;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// result of the request
	always_comb begin
		res = '0;
		case (phase_d)
			xcrc_pkg::PH_IDLE:  res.link_status = xcrc_pkg::LINK_IDLE;
			xcrc_pkg::PH_DONE:  res.link_status = xcrc_pkg::LINK_FINISHED;
			xcrc_pkg::PH_ABORT: res.link_status = xcrc_pkg::LINK_ABORTED;
			default:            res.link_status = xcrc_pkg::LINK_RECEIVING;
		endcase
		case (item.mode)
			xcrc_pkg::MODE_START: begin
				res.block_discard = in_block;
				res.reply_valid   = 1'b1;
				res.reply_byte    = xcrc_pkg::CH_C;
			end
			xcrc_pkg::MODE_CANCEL: begin
				if (receiving) begin
					res.block_discard = in_block;
					res.reply_valid   = 1'b1;
					res.reply_byte    = xcrc_pkg::CH_CAN;
				end
			end
			xcrc_pkg::MODE_TICK: begin
				if (receiving && timeout_hit) begin
					res.block_discard = in_block;
					res.reply_valid   = 1'b1;
					res.reply_byte    = xcrc_pkg::CH_NAK;
				end
			end
			xcrc_pkg::MODE_BYTE: begin
				if (receiving) begin
					case (phase_q)
						xcrc_pkg::PH_WAIT: begin
							if (b == 8'd0) begin
								res.reply_valid = 1'b1;
								res.reply_byte  = xcrc_pkg::CH_NAK;
							end else if (b == xcrc_pkg::CH_EOT) begin
								res.reply_valid = 1'b1;
								res.reply_byte  = xcrc_pkg::CH_ACK;
							end
						end
						xcrc_pkg::PH_CPL: begin
							if (!cpl_ok) begin
								res.reply_valid = 1'b1;
								res.reply_byte  = xcrc_pkg::CH_NAK;
							end
						end
						xcrc_pkg::PH_DATA: begin
							res.data_valid = 1'b1;
							res.data_byte  = b;
							res.data_index = count_q;
						end
						xcrc_pkg::PH_CRCL: begin
							res.reply_valid = 1'b1;
							if (!crc_ok) begin
								res.reply_byte    = xcrc_pkg::CH_NAK;
								res.block_discard = 1'b1;
							end else if (num_new) begin
								res.reply_byte   = xcrc_pkg::CH_ACK;
								res.block_commit = 1'b1;
							end else if (num_dup) begin
								res.reply_byte    = xcrc_pkg::CH_ACK;
								res.block_discard = 1'b1;
							end else begin
								res.reply_byte    = xcrc_pkg::CH_NAK;
								res.block_discard = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= xcrc_pkg::PH_IDLE;
			long_q     <= 1'b0;
			number_q   <= '0;
			count_q    <= '0;
			crc_q      <= '0;
			crc_hi_q   <= '0;
			expected_q <= 8'd1;
			idle_q     <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			long_q     <= long_d;
			number_q   <= number_d;
			count_q    <= count_d;
			crc_q      <= crc_d;
			crc_hi_q   <= crc_hi_d;
			expected_q <= expected_d;
			idle_q     <= idle_d;
		end
	end

	a_commit_not_discard: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(res.block_commit && res.block_discard))
		else $error("commit and discard together");

	a_commit_acks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.block_commit
		|=> phase_q == xcrc_pkg::PH_WAIT && expected_q == $past(expected_q) + 8'd1)
		else $error("commit did not advance the expected block number");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == xcrc_pkg::MODE_START
		|=> phase_q == xcrc_pkg::PH_WAIT && expected_q == 8'd1 && idle_q == 24'd0)
		else $error("start did not restart the transfer");

	a_data_in_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.data_valid |-> phase_q == xcrc_pkg::PH_DATA && item.mode == xcrc_pkg::MODE_BYTE)
		else $error("payload byte outside the data phase");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(crc_q) && $stable(idle_q))
		else $error("state changed without a request");

endmodule

// ===== rtl/core/xmodem_crc_block_receiver.sv =====
// top level of the xmodem-crc block receiver: input register, result register, timeout register
// depends on xcrc_pkg and xcrc_step
//
// usage:
// - input channel (in_valid / in_stall, mode, byte_value) carries one request per transfer:
//   a received byte, a time tick, a cancel request or a start request
// - output channel (out_valid / out_stall) returns exactly one result per request: an optional
//   reply byte to send back (C, ACK, NAK, CAN), an optional payload byte with its index, the
//   block commit / discard flags and the link status after the request
// - config channel (cfg_valid / cfg_ready, cfg_data) writes timeout_ticks; cfg_ready is always
//   high, and it is meant to be written only while no request is in flight
// - path: a request is held in the input register, decided by xcrc_step and stored in the result
//   register, which presents it on the output until it is taken
// - throughput: one request per cycle while out_stall is low; the crc byte update and the phase
//   decision are a single pass of logic between the input register and the result register
// - receiver stall: the result register holds; an empty input register takes one more request,
//   and in_stall is high while the input register holds one, until out_stall drops
// - reset: link idle, expected block number 1, crc and counters cleared, timeout_ticks 60000
module xmodem_crc_block_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reply_valid,
	output logic [7:0]  reply_byte,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic [9:0]  data_index,
	output logic        block_commit,
	output logic        block_discard,
	output logic [1:0]  link_status,
	// timeout register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	logic              item_valid_s1;
	xcrc_pkg::item_t   item_s1;
	logic              res_valid_s2;
	xcrc_pkg::result_t res_s2;
	xcrc_pkg::result_t res;
	logic [23:0]       timeout_q;
	logic              advance, fire;

	// the result register frees up when empty or when its result is taken
	assign advance  = !res_valid_s2 || !out_stall;
	assign fire     = item_valid_s1 && advance;
	assign in_stall = item_valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.mode       <= xcrc_pkg::mode_t'(mode);
			item_s1.byte_value <= byte_value;
		end
	end

	// timeout register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= xcrc_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// protocol state and decision for the request in the input register
	xcrc_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = res_valid_s2;
	assign reply_valid   = res_s2.reply_valid;
	assign reply_byte    = res_s2.reply_byte;
	assign data_valid    = res_s2.data_valid;
	assign data_byte     = res_s2.data_byte;
	assign data_index    = res_s2.data_index;
	assign block_commit  = res_s2.block_commit;
	assign block_discard = res_s2.block_discard;
	assign link_status   = res_s2.link_status;

endmodule
